FILE: rtl/core/mfbp_pkg.sv
// Package for the MSB-first field bit packer: field widths, register codes,
// reset values and the width helpers for the record queue.
// Depends on nothing; every other file of the block uses it.
package mfbp_pkg;

    localparam int MASK_W        = 8;
    localparam int OFFSET_W      = 32;
    localparam int COLOR_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 1;
    localparam int QUEUE_DEPTH   = 2;

    localparam int DEFAULT_MAX_FIELD_WIDTH = 32;

    localparam logic [CFG_DATA_W-1:0] PTR_WIDTH_RESET   = 6'd24;
    localparam logic [CFG_DATA_W-1:0] COLOR_WIDTH_RESET = 6'd32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POINTER_WIDTH = 1'b0,
        CFG_COLOR_WIDTH   = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        FUNC_PACK  = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    // Left-aligned record: child mask followed by two clamped fields.
    function automatic int rec_width(int maxw);
        return MASK_W + 2 * maxw;
    endfunction

    function automatic int len_width(int maxw);
        return $clog2(rec_width(maxw) + 1);
    endfunction

    // Queue entry: flush flag, record length, record bits.
    function automatic int entry_width(int maxw);
        return 1 + len_width(maxw) + rec_width(maxw);
    endfunction

endpackage

FILE: rtl/core/mfbp_if.sv
// Handshake channels of the bit packer: node records in, bytes out.
// Depends on mfbp_pkg for the field widths.
interface mfbp_node_if;
    import mfbp_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [MASK_W-1:0]   child_mask;
    logic [OFFSET_W-1:0] child_offset;
    logic [COLOR_W-1:0]  color;

    modport source (output valid, func, child_mask, child_offset, color, input ready);
    modport sink   (input valid, func, child_mask, child_offset, color, output ready);
endinterface

interface mfbp_byte_if;
    import mfbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: rtl/core/mfbp_front.sv
// Front end of the bit packer: width registers, item classification and
// construction of the left-aligned record. Depends on mfbp_pkg and mfbp_if.
module mfbp_front #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    mfbp_node_if.sink                                        node,
    input  logic                                             cfg_we,
    input  logic [mfbp_pkg::CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [mfbp_pkg::CFG_DATA_W-1:0]                  cfg_data,
    output logic                                             q_valid,
    output logic [mfbp_pkg::entry_width(MAX_FIELD_WIDTH)-1:0] q_data,
    input  logic                                             q_ready
);
    import mfbp_pkg::*;

    localparam int MAXW  = MAX_FIELD_WIDTH;
    localparam int REC_W = rec_width(MAXW);
    localparam int LEN_W = len_width(MAXW);
    localparam int WID_W = $clog2(MAXW + 1);

    logic [CFG_DATA_W-1:0] ptr_width_reg;
    logic [CFG_DATA_W-1:0] color_width_reg;

    logic [WID_W-1:0] ptr_w;
    logic [WID_W-1:0] col_w;
    logic [MAXW-1:0]  off_m;
    logic [MAXW-1:0]  col_m;
    logic [LEN_W-1:0] sh_off;
    logic [LEN_W-1:0] sh_col;
    logic [LEN_W-1:0] rec_len;
    logic [REC_W-1:0] rec;
    logic             is_flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_width_reg   <= PTR_WIDTH_RESET;
            color_width_reg <= COLOR_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_POINTER_WIDTH: ptr_width_reg   <= cfg_data;
                CFG_COLOR_WIDTH:   color_width_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        // Widths above the field limit are clamped to it.
        ptr_w = (int'(ptr_width_reg) > MAXW) ? WID_W'(MAXW) : WID_W'(ptr_width_reg);
        col_w = (int'(color_width_reg) > MAXW) ? WID_W'(MAXW) : WID_W'(color_width_reg);

        off_m = MAXW'(node.child_offset) & ~({MAXW{1'b1}} << ptr_w);
        col_m = MAXW'(node.color) & ~({MAXW{1'b1}} << col_w);

        sh_off = LEN_W'(MAXW) - LEN_W'(ptr_w);
        sh_col = LEN_W'(2 * MAXW) - LEN_W'(ptr_w) - LEN_W'(col_w);

        rec = {node.child_mask, {(2 * MAXW){1'b0}}}
            | ({{MASK_W{1'b0}}, off_m, {MAXW{1'b0}}} << sh_off)
            | ({{(MASK_W + MAXW){1'b0}}, col_m} << sh_col);

        rec_len  = LEN_W'(MASK_W) + LEN_W'(ptr_w) + LEN_W'(col_w);
        is_flush = (node.func == FUNC_FLUSH);
    end

    assign q_valid    = node.valid;
    assign q_data     = {is_flush, rec_len, rec};
    assign node.ready = q_ready;

endmodule

FILE: rtl/core/mfbp_queue.sv
// Short first-in first-out queue that decouples the front and back ends.
// Depends on mfbp_pkg for the default depth.
module mfbp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = mfbp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  logic [DATA_W-1:0] wr_data,
    output logic              wr_ready,
    output logic              rd_valid,
    output logic [DATA_W-1:0] rd_data,
    input  logic              rd_ready
);
    import mfbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/mfbp_back.sv
// Back end of the bit packer: bit buffer, byte extraction and the output
// register. Depends on mfbp_pkg and mfbp_if.
module mfbp_back #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             q_valid,
    input  logic [mfbp_pkg::entry_width(MAX_FIELD_WIDTH)-1:0] q_data,
    output logic                                             q_ready,
    mfbp_byte_if.source                                      stream
);
    import mfbp_pkg::*;

    localparam int REC_W = rec_width(MAX_FIELD_WIDTH);
    localparam int LEN_W = len_width(MAX_FIELD_WIDTH);
    localparam int ENT_W = entry_width(MAX_FIELD_WIDTH);
    localparam int BUF_W = REC_W + BYTE_W - 1;
    localparam int CNT_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  buf_reg;
    logic [BUF_W-1:0]  buf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              e_flush;
    logic [LEN_W-1:0]  e_len;
    logic [REC_W-1:0]  e_rec;
    logic              out_free;
    logic              emit;
    logic [BUF_W-1:0]  res_buf;
    logic [CNT_W-1:0]  res_cnt;
    logic              pop;

    assign e_flush = q_data[ENT_W-1];
    assign e_len   = q_data[REC_W +: LEN_W];
    assign e_rec   = q_data[REC_W-1:0];

    always_comb
    begin
        out_free = !out_valid_reg || stream.ready;
        emit     = (cnt_reg >= CNT_W'(BYTE_W)) && out_free;
        res_buf  = emit ? (buf_reg << BYTE_W) : buf_reg;
        res_cnt  = emit ? (cnt_reg - CNT_W'(BYTE_W)) : cnt_reg;
        // The next record joins once fewer than a byte of bits remain.
        q_ready  = (res_cnt < CNT_W'(BYTE_W));
        pop      = q_valid && q_ready;

        buf_next = res_buf;
        cnt_next = res_cnt;
        if (pop)
        begin
            if (e_flush)
            begin
                // Bits below the fill count are always zero, so padding is free.
                if (res_cnt != '0)
                begin
                    cnt_next = CNT_W'(BYTE_W);
                end
            end
            else
            begin
                buf_next = res_buf | ({e_rec, {(BYTE_W - 1){1'b0}}} >> res_cnt);
                cnt_next = res_cnt + CNT_W'(e_len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= buf_reg[BUF_W-1 -: BYTE_W];
            out_last_reg <= (res_cnt < CNT_W'(BYTE_W));
        end
    end

    assign stream.valid    = out_valid_reg;
    assign stream.out_byte = out_byte_reg;
    assign stream.last     = out_last_reg;

endmodule

FILE: rtl/core/msb_first_field_bit_packer_top.sv
// Top level of the MSB-first field bit packer: front end, record queue and
// back end. Depends on mfbp_pkg, mfbp_if, mfbp_front, mfbp_queue, mfbp_back.
//
// The block packs octree node records into a gap-free byte stream, most
// significant bit first. A pack item writes the 8-bit child mask, then the
// low pointer_width bits of child_offset, then the low color_width bits of
// color; widths above MAX_FIELD_WIDTH are clamped and field bits above bit 31
// read as zero. A flush item pads a partial byte with zeros and emits it, or
// emits nothing when no bits are held. The back end emits one byte per clock
// from its bit buffer while the output is not stalled, so an item occupies it
// until the bytes it completes are out: (held bits + 8 + pointer bits + colour
// bits) / 8 bytes, which is eight for the default widths and nine at most for
// the default field limit, and one byte or none for a flush. The next record
// is merged in the same cycle as the last byte of the one before, so items
// stream without gaps. The front end classifies each transaction and builds
// its left-aligned record combinationally into a two-entry queue, which keeps
// accepting while bytes are still being taken; the first byte of an item then
// passes through the queue, the bit buffer and the output register. The width
// registers are written through cfg_we, cfg_index and cfg_data and take
// effect for items accepted afterwards.
module msb_first_field_bit_packer_top #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mfbp_node_if.sink                        node,
    mfbp_byte_if.source                      stream,
    input  logic                             cfg_we,
    input  logic [mfbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfbp_pkg::*;

    localparam int ENT_W = entry_width(MAX_FIELD_WIDTH);

    // Front end to queue.
    logic             push_valid;
    logic [ENT_W-1:0] push_data;
    logic             push_ready;

    // Queue to back end.
    logic             pop_valid;
    logic [ENT_W-1:0] pop_data;
    logic             pop_ready;

    mfbp_front #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .node      (node),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (push_valid),
        .q_data    (push_data),
        .q_ready   (push_ready)
    );

    mfbp_queue #(
        .DATA_W (ENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_data  (push_data),
        .wr_ready (push_ready),
        .rd_valid (pop_valid),
        .rd_data  (pop_data),
        .rd_ready (pop_ready)
    );

    mfbp_back #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_data  (pop_data),
        .q_ready (pop_ready),
        .stream  (stream)
    );

endmodule

FILE: rtl/core/mfbp_checker.sv
// Port-level checks of the bit packer's output stream, and the bind that
// attaches them to the top level. Depends on msb_first_field_bit_packer_top.
module mfbp_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic [mfbp_pkg::BYTE_W-1:0] out_byte
);

    // A stalled byte is held unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output byte changed or was dropped");

    // No byte is offered straight after reset.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

    // The bytes of one transaction follow each other without a gap.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside the bytes of one transaction");

endmodule

bind msb_first_field_bit_packer_top mfbp_checker u_mfbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (stream.valid),
    .out_ready (stream.ready),
    .out_last  (stream.last),
    .out_byte  (stream.out_byte)
);
